// ===== hdl/sample_dma_buffer_cache_macros.svh =====
// ----------------------------------------------------------------------------
// Sample DMA buffer cache assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_DMA_BUFFER_CACHE_MACROS_SVH
`define SAMPLE_DMA_BUFFER_CACHE_MACROS_SVH

// same-cycle implication
`define SDBC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdbc assertion failed");

// next-cycle implication
`define SDBC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdbc assertion failed");

`endif

// ===== hdl/sdbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sample DMA buffer cache package
// Field widths, defaults and the records passed along the cell chain.
// ----------------------------------------------------------------------------
package sdbc_pkg;

  localparam int AddrW   = 31;
  localparam int LenW    = 16;
  localparam int FrameW  = 32;
  localparam int IndexW  = 5;
  localparam int OffsetW = 11;
  localparam int EndW    = 32;

  localparam int DefNumBuffers   = 32;
  localparam int DefBufferLength = 1024;

  typedef struct packed {
    logic              active;
    logic              done;
    logic              hit;
    logic [AddrW-1:0]  addr;
    logic [EndW-1:0]   addr_end;
    logic [FrameW-1:0] frame;
    logic [OffsetW-1:0] offset;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [AddrW-1:0]  start;
    logic [FrameW-1:0] frame;
  } ins_t;

endpackage

// ===== hdl/sdbc_cell.sv =====
// ----------------------------------------------------------------------------
// Sample DMA buffer cache cell
// Holds one used-list entry, tests the passing request against its window
// and shifts its entry to the right neighbor on insertion.
// ----------------------------------------------------------------------------
module sdbc_cell #(
  parameter int NUM_BUFFERS   = sdbc_pkg::DefNumBuffers,
  parameter int BUFFER_LENGTH = sdbc_pkg::DefBufferLength,
  parameter int CELL_IDX      = 0,
  localparam int IdW  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1,
  localparam int PosW = $clog2(NUM_BUFFERS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [PosW-1:0]              used_count,
  input  sdbc_pkg::tok_t               tok_in,
  input  logic [PosW-1:0]              pos_in,
  input  logic [IdW-1:0]               rid_in,
  output sdbc_pkg::tok_t               tok_out,
  output logic [PosW-1:0]              pos_out,
  output logic [IdW-1:0]               rid_out,
  input  sdbc_pkg::ins_t               ins,
  input  logic [PosW-1:0]              ins_pos,
  input  logic [IdW-1:0]               ins_id,
  input  logic [sdbc_pkg::AddrW-1:0]   left_start,
  input  logic [sdbc_pkg::FrameW-1:0]  left_frame,
  input  logic [IdW-1:0]               left_id,
  output logic [sdbc_pkg::AddrW-1:0]   start,
  output logic [sdbc_pkg::FrameW-1:0]  frame,
  output logic [IdW-1:0]               id
);

  localparam logic [PosW-1:0] MyPos   = PosW'(CELL_IDX);
  localparam logic [PosW-1:0] NextPos = PosW'(CELL_IDX + 1);

  logic [sdbc_pkg::AddrW-1:0]  start_r, start_nxt;
  logic [sdbc_pkg::FrameW-1:0] frame_r, frame_nxt;
  logic [IdW-1:0]              id_r, id_nxt;
  sdbc_pkg::tok_t              tok_r, tok_nxt;
  logic                        act_r;
  logic [PosW-1:0]             pos_r, pos_nxt;
  logic [IdW-1:0]              rid_r, rid_nxt;

  logic                        in_use;
  logic [sdbc_pkg::EndW-1:0]   limit;
  logic [sdbc_pkg::AddrW-1:0]  diff;

  assign in_use = MyPos < used_count;
  assign limit  = {1'b0, start_r} + sdbc_pkg::EndW'(BUFFER_LENGTH);
  assign diff   = tok_in.addr - start_r;

  always_comb begin
    tok_nxt   = tok_in;
    pos_nxt   = pos_in;
    rid_nxt   = rid_in;
    start_nxt = start_r;
    frame_nxt = frame_r;
    id_nxt    = id_r;
    if (tok_in.active && !tok_in.done) begin
      priority if (!in_use) begin
        tok_nxt.done = 1'b1;
      end else if (start_r > tok_in.addr) begin
        tok_nxt.done = 1'b1;
        if (CELL_IDX == 0) begin
          rid_nxt = id_r;
        end
      end else if (tok_in.addr_end <= limit) begin
        tok_nxt.done   = 1'b1;
        tok_nxt.hit    = 1'b1;
        tok_nxt.offset = diff[sdbc_pkg::OffsetW-1:0];
        rid_nxt        = id_r;
        frame_nxt      = tok_in.frame;
      end else begin
        pos_nxt = NextPos;
        rid_nxt = id_r;
      end
    end
    if (ins.en) begin
      priority if (MyPos > ins_pos) begin
        start_nxt = left_start;
        frame_nxt = left_frame;
        id_nxt    = left_id;
      end else if (MyPos == ins_pos) begin
        start_nxt = ins.start;
        frame_nxt = ins.frame;
        id_nxt    = ins_id;
      end else begin
        start_nxt = start_r;
        id_nxt    = id_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= tok_in.active;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    frame_r <= frame_nxt;
    id_r    <= id_nxt;
    tok_r   <= tok_nxt;
    pos_r   <= pos_nxt;
    rid_r   <= rid_nxt;
  end

  always_comb begin
    tok_out        = tok_r;
    tok_out.active = act_r;
  end

  assign pos_out = pos_r;
  assign rid_out = rid_r;
  assign start   = start_r;
  assign frame   = frame_r;
  assign id      = id_r;

endmodule

// ===== hdl/sample_dma_buffer_cache.sv =====
// ----------------------------------------------------------------------------
// Sample DMA buffer cache
// Looks up sample fetch requests in a sorted list of DMA-filled buffers and
// allocates a free buffer, with a fill request, on a miss while one is free.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request transaction: address,
//   length and frame number. Output channel (out_valid/out_ready) returns one
//   result transaction per request: hit, buffer index, byte offset, DMA fill
//   request and address, and the no-free-buffer flag.
//   The request walks a chain of NUM_BUFFERS cells, one cell per cycle, each
//   cell holding one used-list entry in address order. A new request is
//   taken only once the last one has left the chain and the result register
//   is empty, so one request is in the chain at a time. A miss, while a
//   buffer is free, inserts the new buffer by shifting the cells behind its
//   position one place right.
//   A result register and an output register decouple the receiver: a new
//   request is taken while a result waits on out_ready; when both registers
//   are full, in_ready stays low until the receiver takes a result.
//   Reset empties the used list and frees all buffers; no clearing pass.
// ----------------------------------------------------------------------------
`include "sample_dma_buffer_cache_macros.svh"

module sample_dma_buffer_cache #(
  parameter int NUM_BUFFERS   = sdbc_pkg::DefNumBuffers,
  parameter int BUFFER_LENGTH = sdbc_pkg::DefBufferLength
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sdbc_pkg::AddrW-1:0]    in_address,
  input  logic [sdbc_pkg::LenW-1:0]     in_length,
  input  logic [sdbc_pkg::FrameW-1:0]   in_frame_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [sdbc_pkg::IndexW-1:0]   out_buffer_index,
  output logic [sdbc_pkg::OffsetW-1:0]  out_byte_offset,
  output logic                          out_dma_request,
  output logic [sdbc_pkg::AddrW-1:0]    out_dma_address,
  output logic                          out_no_buffer
);

  localparam int IdW  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int PosW = $clog2(NUM_BUFFERS + 1);

  sdbc_pkg::tok_t              tok_c [NUM_BUFFERS+1];
  logic [PosW-1:0]             pos_c [NUM_BUFFERS+1];
  logic [IdW-1:0]              rid_c [NUM_BUFFERS+1];
  logic [sdbc_pkg::AddrW-1:0]  start_w [NUM_BUFFERS];
  logic [sdbc_pkg::FrameW-1:0] frame_w [NUM_BUFFERS];
  logic [IdW-1:0]              id_w [NUM_BUFFERS];

  sdbc_pkg::tok_t              tok0_r, tok0_nxt;
  logic                        act0_r;
  logic                        busy_r;
  logic [PosW-1:0]             used_r, used_nxt;

  logic                        res_valid_r;
  logic                        res_hit_r, res_hit_nxt;
  logic [sdbc_pkg::IndexW-1:0] res_index_r, res_index_nxt;
  logic [sdbc_pkg::OffsetW-1:0] res_offset_r, res_offset_nxt;
  logic                        res_dma_r, res_dma_nxt;
  logic [sdbc_pkg::AddrW-1:0]  res_dma_addr_r, res_dma_addr_nxt;
  logic                        res_nobuf_r, res_nobuf_nxt;

  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [sdbc_pkg::IndexW-1:0] out_index_r;
  logic [sdbc_pkg::OffsetW-1:0] out_offset_r;
  logic                        out_dma_r;
  logic [sdbc_pkg::AddrW-1:0]  out_dma_addr_r;
  logic                        out_nobuf_r;

  logic                        accept;
  logic                        exit_w;
  logic                        full;
  logic                        move;
  logic [IdW-1:0]              new_id;
  logic [IdW-1:0]              idx_sel;
  logic [sdbc_pkg::AddrW-1:0]  even_addr;
  sdbc_pkg::ins_t              ins;

  assign in_ready = !busy_r && !res_valid_r;
  assign accept   = in_valid && in_ready;

  always_comb begin
    tok0_nxt          = tok0_r;
    tok0_nxt.active   = 1'b1;
    tok0_nxt.done     = 1'b0;
    tok0_nxt.hit      = 1'b0;
    tok0_nxt.addr     = in_address;
    tok0_nxt.addr_end = sdbc_pkg::EndW'(in_address) + sdbc_pkg::EndW'(in_length);
    tok0_nxt.frame    = in_frame_number;
    tok0_nxt.offset   = '0;
  end

  always_comb begin
    tok_c[0]        = tok0_r;
    tok_c[0].active = act0_r;
  end
  assign pos_c[0] = '0;
  assign rid_c[0] = '0;

  for (genvar i = 0; i < NUM_BUFFERS; i++) begin : g_cell
    if (i == 0) begin : g_head
      sdbc_cell #(
        .NUM_BUFFERS   (NUM_BUFFERS),
        .BUFFER_LENGTH (BUFFER_LENGTH),
        .CELL_IDX      (i)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .used_count (used_r),
        .tok_in     (tok_c[i]),
        .pos_in     (pos_c[i]),
        .rid_in     (rid_c[i]),
        .tok_out    (tok_c[i+1]),
        .pos_out    (pos_c[i+1]),
        .rid_out    (rid_c[i+1]),
        .ins        (ins),
        .ins_pos    (pos_c[NUM_BUFFERS]),
        .ins_id     (new_id),
        .left_start ('0),
        .left_frame ('0),
        .left_id    ('0),
        .start      (start_w[i]),
        .frame      (frame_w[i]),
        .id         (id_w[i])
      );
    end else begin : g_body
      sdbc_cell #(
        .NUM_BUFFERS   (NUM_BUFFERS),
        .BUFFER_LENGTH (BUFFER_LENGTH),
        .CELL_IDX      (i)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .used_count (used_r),
        .tok_in     (tok_c[i]),
        .pos_in     (pos_c[i]),
        .rid_in     (rid_c[i]),
        .tok_out    (tok_c[i+1]),
        .pos_out    (pos_c[i+1]),
        .rid_out    (rid_c[i+1]),
        .ins        (ins),
        .ins_pos    (pos_c[NUM_BUFFERS]),
        .ins_id     (new_id),
        .left_start (start_w[i-1]),
        .left_frame (frame_w[i-1]),
        .left_id    (id_w[i-1]),
        .start      (start_w[i]),
        .frame      (frame_w[i]),
        .id         (id_w[i])
      );
    end
  end

  assign exit_w    = tok_c[NUM_BUFFERS].active;
  assign full      = used_r == PosW'(NUM_BUFFERS);
  assign new_id    = used_r[IdW-1:0];
  assign even_addr = {tok_c[NUM_BUFFERS].addr[sdbc_pkg::AddrW-1:1], 1'b0};

  always_comb begin
    ins.en    = exit_w && !tok_c[NUM_BUFFERS].hit && !full;
    ins.start = even_addr;
    ins.frame = tok_c[NUM_BUFFERS].frame;
  end

  assign idx_sel  = ins.en ? new_id : rid_c[NUM_BUFFERS];
  assign used_nxt = used_r + PosW'(ins.en);

  always_comb begin
    res_hit_nxt      = tok_c[NUM_BUFFERS].hit;
    res_index_nxt    = sdbc_pkg::IndexW'({{sdbc_pkg::IndexW{1'b0}}, idx_sel});
    res_offset_nxt   = tok_c[NUM_BUFFERS].hit ? tok_c[NUM_BUFFERS].offset
                       : sdbc_pkg::OffsetW'(tok_c[NUM_BUFFERS].addr[0]);
    res_dma_nxt      = ins.en;
    res_dma_addr_nxt = ins.en ? even_addr : '0;
    res_nobuf_nxt    = !tok_c[NUM_BUFFERS].hit && full;
  end

  assign move = res_valid_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act0_r      <= 1'b0;
      busy_r      <= 1'b0;
      used_r      <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act0_r <= accept;
      priority if (accept) begin
        busy_r <= 1'b1;
      end else if (exit_w) begin
        busy_r <= 1'b0;
      end else begin
        busy_r <= busy_r;
      end
      used_r <= used_nxt;
      priority if (exit_w) begin
        res_valid_r <= 1'b1;
      end else if (move) begin
        res_valid_r <= 1'b0;
      end else begin
        res_valid_r <= res_valid_r;
      end
      priority if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok0_r <= tok0_nxt;
    end
    if (exit_w) begin
      res_hit_r      <= res_hit_nxt;
      res_index_r    <= res_index_nxt;
      res_offset_r   <= res_offset_nxt;
      res_dma_r      <= res_dma_nxt;
      res_dma_addr_r <= res_dma_addr_nxt;
      res_nobuf_r    <= res_nobuf_nxt;
    end
    if (move) begin
      out_hit_r      <= res_hit_r;
      out_index_r    <= res_index_r;
      out_offset_r   <= res_offset_r;
      out_dma_r      <= res_dma_r;
      out_dma_addr_r <= res_dma_addr_r;
      out_nobuf_r    <= res_nobuf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_buffer_index = out_index_r;
  assign out_byte_offset  = out_offset_r;
  assign out_dma_request  = out_dma_r;
  assign out_dma_address  = out_dma_addr_r;
  assign out_no_buffer    = out_nobuf_r;

  `SDBC_ASSERT_IMP(a_exit_while_busy, exit_w, busy_r)
  `SDBC_ASSERT_IMP(a_used_bound, 1'b1, used_r <= PosW'(NUM_BUFFERS))
  `SDBC_ASSERT_IMP(a_result_kind, out_valid_r, !(out_dma_r && (out_hit_r || out_nobuf_r)))
  `SDBC_ASSERT_NXT(a_res_hold, res_valid_r && out_valid_r && !out_ready, res_valid_r)

endmodule
